// File: hdl/sdeq_pkg.sv
// Package for the sorted double-ended queue: sizes, operation and status
// codes, and the structs that pass between the top level and the cells.
// Has no dependencies.
package sdeq_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned DataW    = 32;
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned CountW   = 5;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_REM_MIN = 2'd1,
    OP_REM_MAX = 2'd2,
    OP_QUERY   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Command broadcast to every cell
  typedef struct packed {
    logic                    en;
    op_e                     op;
    logic signed [DataW-1:0] value;
  } cell_cmd_t;

  // What a cell shows to its right-hand neighbor
  typedef struct packed {
    logic signed [DataW-1:0] entry;
    logic                    occ;
    logic                    gt;
  } cell_nbr_t;

endpackage

// File: hdl/sorted_double_ended_queue_core.sv
// Top level of the sorted double-ended queue: a chain of sdeq_cell slots,
// the fill count and the result register. Depends on sdeq_pkg, sdeq_cell.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries an operation and a value:
//   insert, remove smallest, remove largest, or membership query.
//   Output channel (out_valid_o/out_ready_i) returns one result per item:
//   status, found flag, smallest, largest and count after the operation.
//   Every cell compares the broadcast value with its own entry and takes
//   its own, its neighbor's or the new value in the same cycle, so the
//   result of an item is valid the cycle after acceptance.
//   Throughput is one item per cycle while out_ready_i stays high; the
//   single result register is the only buffer, so a stalled receiver holds
//   in_ready_o low until the waiting result is taken.
//   Smallest and largest come straight from the cell chain, which does not
//   change while a result waits.
//   Reset clears the fill count and the result valid; entry contents are
//   not cleared and are never shown while not filled.
//   Insert into a full store and removal from an empty one are refused
//   with a status code and leave the contents unchanged.
module sorted_double_ended_queue_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        operation_i,
  input  logic signed [sdeq_pkg::DataW-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        status_o,
  output logic                              found_o,
  output logic signed [sdeq_pkg::DataW-1:0] smallest_o,
  output logic signed [sdeq_pkg::DataW-1:0] largest_o,
  output logic [sdeq_pkg::CountW-1:0]       count_o
);
  import sdeq_pkg::*;

  op_e                     op;
  logic                    accept;
  logic                    full, empty, refuse;
  cell_cmd_t               cmd;
  cell_nbr_t               nbr    [Capacity];
  cell_nbr_t               left   [Capacity];
  logic signed [DataW-1:0] right  [Capacity];
  logic [Capacity-1:0]     occ;
  logic [Capacity-1:0]     match;
  logic [Capacity-1:0]     last;
  logic signed [DataW-1:0] largest;
  logic [CntW-1:0]         count_q, count_d;
  logic                    out_valid_q;
  status_e                 status_q, status_d;
  logic                    found_q;

  assign op         = op_e'(operation_i);
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CntW'(Capacity));
  assign empty      = (count_q == '0);

  // Refuse insert into full and removals from empty
  always_comb begin
    unique case (op)
      OP_INSERT:  status_d = full  ? ST_FULL  : ST_OK;
      OP_REM_MIN: status_d = empty ? ST_EMPTY : ST_OK;
      OP_REM_MAX: status_d = empty ? ST_EMPTY : ST_OK;
      OP_QUERY:   status_d = ST_OK;
      default:    status_d = ST_OK;
    endcase
  end
  assign refuse = (status_d != ST_OK);

  assign cmd.en    = accept && !refuse;
  assign cmd.op    = op;
  assign cmd.value = value_i;

  // Wire up the chain of cells
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    assign occ[i]  = (CntW'(i) < count_q);
    assign last[i] = (count_q == CntW'(i + 1));
    if (i == 0) begin : g_first
      assign left[i] = '{entry: '0, occ: 1'b1, gt: 1'b0};
    end else begin : g_mid
      assign left[i] = nbr[i-1];
    end
    if (i == Capacity - 1) begin : g_last
      assign right[i] = '0;
    end else begin : g_notlast
      assign right[i] = nbr[i+1].entry;
    end
    sdeq_cell u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .occ_i         (occ[i]),
      .left_i        (left[i]),
      .right_entry_i (right[i]),
      .nbr_o         (nbr[i]),
      .match_o       (match[i])
    );
  end

  // Pick the entry at the top of the filled range
  always_comb begin
    largest = '0;
    for (int unsigned i = 0; i < Capacity; i++) begin
      largest = largest | (last[i] ? nbr[i].entry : '0);
    end
  end

  // Advance the fill count
  always_comb begin
    count_d = count_q;
    if (cmd.en) begin
      unique case (op)
        OP_INSERT:  count_d = count_q + CntW'(1);
        OP_REM_MIN: count_d = count_q - CntW'(1);
        OP_REM_MAX: count_d = count_q - CntW'(1);
        OP_QUERY:   count_d = count_q;
        default:    count_d = count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  // Hold status and found for the waiting item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      found_q  <= (op == OP_QUERY) && (|match);
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign found_o     = found_q;
  assign smallest_o  = empty ? '0 : nbr[0].entry;
  assign largest_o   = largest;
  assign count_o     = CountW'(count_q);

endmodule

// File: hdl/sdeq_cell.sv
// One slot of the sorted chain: holds one entry and moves it left or right.
// Depends on sdeq_pkg.
module sdeq_cell (
  input  logic                           clk_i,
  input  sdeq_pkg::cell_cmd_t            cmd_i,
  input  logic                           occ_i,
  input  sdeq_pkg::cell_nbr_t            left_i,
  input  logic signed [sdeq_pkg::DataW-1:0] right_entry_i,
  output sdeq_pkg::cell_nbr_t            nbr_o,
  output logic                           match_o
);
  import sdeq_pkg::*;

  logic signed [DataW-1:0] entry_q, entry_d;
  logic                    gt;

  // Compare the held entry against the command value
  assign gt      = occ_i && (entry_q > cmd_i.value);
  assign match_o = occ_i && (entry_q == cmd_i.value);

  assign nbr_o.entry = entry_q;
  assign nbr_o.occ   = occ_i;
  assign nbr_o.gt    = gt;

  // Shift right on insert, left on remove-smallest, hold otherwise
  always_comb begin
    entry_d = entry_q;
    if (cmd_i.en) begin
      unique case (cmd_i.op)
        OP_INSERT: begin
          if (left_i.gt) begin
            entry_d = left_i.entry;
          end else if (gt || (!occ_i && left_i.occ)) begin
            entry_d = cmd_i.value;
          end
        end
        OP_REM_MIN: entry_d = right_entry_i;
        OP_REM_MAX: entry_d = entry_q;
        OP_QUERY:   entry_d = entry_q;
        default:    entry_d = entry_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// File: dv/tb_sorted_double_ended_queue_core.sv
// Testbench for sorted_double_ended_queue_core: directed and random insert,
// remove and query items checked against a queue-based prediction of the
// sorted store. Depends on sdeq_pkg and the core RTL.
module tb_sorted_double_ended_queue_core;
  import sdeq_pkg::*;

  typedef struct {
    op_e                     op;
    logic signed [DataW-1:0] value;
    int                      gap;
    bit                      drain;
  } cmd_t;

  typedef struct {
    status_e                 status;
    logic                    found;
    logic signed [DataW-1:0] smallest;
    logic signed [DataW-1:0] largest;
    logic [CountW-1:0]       count;
  } result_t;

  localparam logic signed [DataW-1:0] MinVal = {1'b1, {(DataW-1){1'b0}}};
  localparam logic signed [DataW-1:0] MaxVal = {1'b0, {(DataW-1){1'b1}}};

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready_o;
  logic [1:0]              op_drv = OP_QUERY;
  logic signed [DataW-1:0] value_drv = '0;
  logic                    out_valid_o;
  logic                    out_ready = 1'b0;
  logic [1:0]              status_o;
  logic                    found_o;
  logic signed [DataW-1:0] smallest_o;
  logic signed [DataW-1:0] largest_o;
  logic [CountW-1:0]       count_o;

  sorted_double_ended_queue_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .operation_i (op_drv),
    .value_i     (value_drv),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .status_o    (status_o),
    .found_o     (found_o),
    .smallest_o  (smallest_o),
    .largest_o   (largest_o),
    .count_o     (count_o)
  );

  always #2 clk_i = ~clk_i;

  cmd_t                    pending_cmds[$];
  result_t                 expected_results[$];
  logic signed [DataW-1:0] shadow_sorted[$];
  logic signed [DataW-1:0] value_pool[$];
  cmd_t                    cur_cmd;
  bit                      item_taken;
  int                      gap_left;
  int                      err_cnt;
  int                      items_taken;
  int                      results_seen;
  int                      op_hits[4];
  int                      full_refusals;
  int                      empty_refusals;
  int                      query_hits;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 13) return 0;
    if (sel < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // Apply one operation to the shadow store and build its result
  function automatic result_t predict_result(op_e op, logic signed [DataW-1:0] v);
    result_t r;
    int      pos;
    r.status = ST_OK;
    r.found  = 1'b0;
    case (op)
      OP_INSERT: begin
        if (shadow_sorted.size() >= Capacity) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < shadow_sorted.size() && shadow_sorted[pos] <= v) pos++;
          shadow_sorted.insert(pos, v);
        end
      end
      OP_REM_MIN: begin
        if (shadow_sorted.size() == 0) r.status = ST_EMPTY;
        else void'(shadow_sorted.pop_front());
      end
      OP_REM_MAX: begin
        if (shadow_sorted.size() == 0) r.status = ST_EMPTY;
        else void'(shadow_sorted.pop_back());
      end
      default: begin
        foreach (shadow_sorted[i]) if (shadow_sorted[i] == v) r.found = 1'b1;
      end
    endcase
    if (shadow_sorted.size() == 0) begin
      r.smallest = '0;
      r.largest  = '0;
    end else begin
      r.smallest = shadow_sorted[0];
      r.largest  = shadow_sorted[shadow_sorted.size()-1];
    end
    r.count = CountW'(shadow_sorted.size());
    return r;
  endfunction

  task automatic check_field(string name, logic [DataW-1:0] want, logic [DataW-1:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d (0x%h) got %0d (0x%h)", $time, name,
               $signed(want), want, $signed(got), got);
    end
  endtask

  // Monitor: check each result, then record and predict each accepted item
  always @(posedge clk_i) begin
    result_t want;
    item_taken = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result, status %0d count %0d", $time, status_o, count_o);
        end else begin
          want = expected_results.pop_front();
          check_field("status", DataW'(want.status), DataW'(status_o));
          check_field("found", DataW'(want.found), DataW'(found_o));
          check_field("smallest", want.smallest, smallest_o);
          check_field("largest", want.largest, largest_o);
          check_field("count", DataW'(want.count), DataW'(count_o));
        end
      end
      if (in_valid && in_ready_o) begin
        item_taken = 1'b1;
        items_taken++;
        want = predict_result(op_e'(op_drv), value_drv);
        op_hits[op_drv]++;
        if (want.status == ST_FULL) full_refusals++;
        if (want.status == ST_EMPTY) empty_refusals++;
        if (want.found) query_hits++;
        expected_results.push_back(want);
      end
    end
  end

  // Driver: present the next item, honoring gaps and drain markers
  always @(negedge clk_i) begin
    logic nxt_valid;
    cmd_t nxt;
    nxt_valid = in_valid;
    nxt       = cur_cmd;
    if (rst_ni) begin
      if (item_taken) begin
        nxt_valid = 1'b0;
        gap_left  = cur_cmd.gap;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() > 0) begin
          if (pending_cmds[0].drain) begin
            if (expected_results.size() == 0) void'(pending_cmds.pop_front());
          end else begin
            nxt       = pending_cmds.pop_front();
            nxt_valid = 1'b1;
          end
        end
      end
    end
    cur_cmd   = nxt;
    in_valid  <= nxt_valid;
    op_drv    <= nxt.op;
    value_drv <= nxt.value;
  end

  // Receiver: random stalls, calm stretches, and one long hold-off
  int  stall_left;
  int  calm_left;
  bit  calm;
  bit  long_hold_done;
  always @(negedge clk_i) begin
    logic nxt_ready;
    nxt_ready = 1'b0;
    if (rst_ni) begin
      if (calm_left == 0) begin
        calm_left = 64;
        calm      = ($urandom_range(0, 2) == 0);
      end else begin
        calm_left--;
      end
      if (!long_hold_done && items_taken >= 150) begin
        long_hold_done = 1'b1;
        stall_left     = 60;
      end
      if (stall_left > 0) begin
        stall_left--;
      end else begin
        nxt_ready = 1'b1;
        if (!calm) stall_left = pick_gap();
      end
    end
    out_ready <= nxt_ready;
  end

  // Stimulus helpers
  bit seg_calm;

  task automatic add_item(op_e op, logic signed [DataW-1:0] v);
    cmd_t c;
    c.op    = op;
    c.value = v;
    c.gap   = seg_calm ? 0 : pick_gap();
    c.drain = 1'b0;
    pending_cmds.push_back(c);
    if (op == OP_INSERT) begin
      value_pool.push_back(v);
      if (value_pool.size() > 16) void'(value_pool.pop_front());
    end
  endtask

  task automatic add_drain();
    cmd_t c;
    c.op    = OP_QUERY;
    c.value = '0;
    c.gap   = 0;
    c.drain = 1'b1;
    pending_cmds.push_back(c);
  endtask

  function automatic logic signed [DataW-1:0] rand_value();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $signed($urandom_range(0, 12)) - 6;
      2: begin
        case ($urandom_range(0, 3))
          0: return MinVal;
          1: return MaxVal;
          2: return '0;
          default: return '1;
        endcase
      end
      default: begin
        if (value_pool.size() == 0) return $urandom();
        return value_pool[$urandom_range(0, value_pool.size()-1)];
      end
    endcase
  endfunction

  // Pick an operation biased by the segment mode
  function automatic op_e pick_op(int mode);
    int roll;
    roll = $urandom_range(0, 9);
    case (mode)
      0: return (roll < 8) ? OP_INSERT : op_e'($urandom_range(1, 3));
      1: return (roll < 8) ? op_e'($urandom_range(1, 2)) : op_e'($urandom_range(0, 3));
      3: return (roll < 6) ? OP_QUERY : op_e'($urandom_range(0, 2));
      default: return op_e'($urandom_range(0, 3));
    endcase
  endfunction

  // Build stimulus, run reset, wait for completion
  initial begin
    int n_rand;
    int seg_len;
    int mode;
    seg_calm = 1'b0;

    // Directed: empty store, extremes, duplicates, removal of the last entry
    add_item(OP_REM_MIN, '0);
    add_item(OP_REM_MAX, '1);
    add_item(OP_QUERY, '0);
    add_item(OP_INSERT, MaxVal);
    add_item(OP_INSERT, MinVal);
    add_item(OP_INSERT, '0);
    add_item(OP_INSERT, '1);
    add_item(OP_INSERT, '0);
    add_item(OP_QUERY, '0);
    add_item(OP_QUERY, 1);
    add_item(OP_QUERY, MinVal);
    add_item(OP_QUERY, MaxVal);
    add_item(OP_REM_MAX, '0);
    add_item(OP_QUERY, MaxVal);
    add_item(OP_REM_MIN, '0);
    add_item(OP_REM_MIN, '0);
    add_item(OP_REM_MAX, '0);
    add_item(OP_REM_MAX, '0);
    add_item(OP_REM_MIN, '0);
    add_item(OP_QUERY, '1);
    add_item(OP_INSERT, 5);
    add_item(OP_REM_MIN, '0);
    add_drain();

    // Fill past capacity, then drain past empty
    for (int i = 0; i < Capacity + 2; i++) add_item(OP_INSERT, rand_value());
    add_item(OP_QUERY, rand_value());
    for (int i = 0; i < Capacity + 2; i++) add_item(op_e'($urandom_range(1, 2)), rand_value());
    n_rand = 2 * Capacity + 5;

    // Random segments with a mode each; pause for a full drain now and then
    while (n_rand < 550) begin
      seg_len  = $urandom_range(10, 40);
      mode     = $urandom_range(0, 3);
      seg_calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < seg_len; i++) add_item(pick_op(mode), rand_value());
      n_rand += seg_len;
      if ($urandom_range(0, 5) == 0) add_drain();
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (expected_results.size() != 0) err_cnt++;

    $display("ran %0d items (insert %0d, remove min %0d, remove max %0d, query %0d)",
             items_taken, op_hits[OP_INSERT], op_hits[OP_REM_MIN], op_hits[OP_REM_MAX],
             op_hits[OP_QUERY]);
    $display("checked %0d results: %0d full refusals, %0d empty refusals, %0d query hits",
             results_seen, full_refusals, empty_refusals, query_hits);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hard stop in case the handshake hangs
  initial begin
    #1_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("status: fail");
    $finish;
  end

endmodule
